// ----- rtl/pal_pkg.sv -----
`default_nettype none
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int CNT_W    = POS_W;
  localparam int ST_W     = 3;

  localparam int IN_BITS   = OP_W + POS_W + DATA_W;
  localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = ST_W + DATA_W + POS_W + CNT_W;
  localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam op_t OP_CLEAR  = 3'd0;
  localparam op_t OP_INSERT = 3'd1;
  localparam op_t OP_DELETE = 3'd2;
  localparam op_t OP_LOCATE = 3'd3;
  localparam op_t OP_GET    = 3'd4;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_BADPOS   = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage
`default_nettype wire

// ----- rtl/pal_ram.sv -----
`default_nettype none
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/positional_array_list_unit.sv -----
`default_nettype none
// bounded ordered list held in one single-port-read / single-port-write ram
// clear, failures and unused opcodes go straight to the result; get, locate, delete and insert
//   walk the ram first, locate stops at its first hit and insert then writes the new value
// throughput: one item at a time; the walk through the ram (one entry per cycle) sets it,
//   in_tready returns with the result and a held output register stalls the finish
// reset: entry count, controller state, output valid, walk flags and read count cleared; ram contents are not cleared
module positional_array_list_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // opcode [2:0], position [9:3], item_value [41:10], zero fill above
  input  wire logic [pal_pkg::IN_TW-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // status [2:0], read_value [34:3], found_position [41:35], list_length [48:42]
  output logic      [pal_pkg::OUT_TW-1:0] out_tdata
);

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_INSWR = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam int OW = pal_pkg::OP_W;
  localparam int PW = pal_pkg::POS_W;

  // unpacked input fields
  pal_pkg::op_t   in_op;
  pal_pkg::cnt_t  in_pos;
  pal_pkg::data_t in_val;
  pal_pkg::cnt_t  pos_m1;

  assign in_op  = in_tdata[OW-1:0];
  assign in_pos = in_tdata[OW+PW-1:OW];
  assign in_val = in_tdata[OW+PW+pal_pkg::DATA_W-1:OW+PW];
  assign pos_m1 = in_pos - pal_pkg::CNT_W'(1);

  logic [1:0]          state_r, state_nxt;
  pal_pkg::op_t        op_r, op_nxt;
  pal_pkg::data_t      val_r, val_nxt;
  pal_pkg::addr_t      ins_addr_r, ins_addr_nxt;   // target slot of an insert
  pal_pkg::cnt_t       rem_r, rem_nxt;             // reads still to issue
  pal_pkg::addr_t      rd_addr_r, rd_addr_nxt;
  logic                first_r, first_nxt;         // next read is the first one
  logic                pend_r, pend_nxt;           // ram read data arrives this cycle
  logic                pend_first_r, pend_first_nxt;
  pal_pkg::addr_t      pend_addr_r, pend_addr_nxt;
  pal_pkg::status_t    status_r, status_nxt;
  pal_pkg::data_t      rv_r, rv_nxt;
  pal_pkg::cnt_t       fp_r, fp_nxt;
  pal_pkg::cnt_t       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [pal_pkg::OUT_TW-1:0] out_data_r, out_data_nxt;

  logic           ram_we;
  pal_pkg::addr_t ram_waddr;
  pal_pkg::data_t ram_wdata;
  pal_pkg::data_t ram_rdata;

  pal_ram #(
    .WIDTH (pal_pkg::DATA_W),
    .DEPTH (pal_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic walk_up;
  logic loc_hit;

  // insert walks down from the tail, every other walk goes up
  assign walk_up = (op_r != pal_pkg::OP_INSERT);
  assign loc_hit = (op_r == pal_pkg::OP_LOCATE) && pend_r && (ram_rdata == val_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    ins_addr_nxt   = ins_addr_r;
    rem_nxt        = rem_r;
    rd_addr_nxt    = rd_addr_r;
    first_nxt      = first_r;
    pend_nxt       = pend_r;
    pend_first_nxt = pend_first_r;
    pend_addr_nxt  = pend_addr_r;
    status_nxt     = status_r;
    rv_nxt         = rv_r;
    fp_nxt         = fp_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr_r;
    ram_wdata      = ram_rdata;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_op;
          val_nxt      = in_val;
          ins_addr_nxt = pos_m1[pal_pkg::ADDR_W-1:0];
          status_nxt   = pal_pkg::ST_OK;
          rv_nxt       = '0;
          fp_nxt       = '0;
          first_nxt    = 1'b1;
          pend_nxt     = 1'b0;
          state_nxt    = S_FIN;
          case (in_op)
            pal_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            pal_pkg::OP_INSERT: begin
              if (count_r >= pal_pkg::CNT_W'(pal_pkg::CAPACITY)) begin
                status_nxt = pal_pkg::ST_FULL;
              end else if (in_pos == '0 || in_pos > count_r + pal_pkg::CNT_W'(1)) begin
                status_nxt = pal_pkg::ST_BADPOS;
              end else begin
                // move entries position-1 .. length-1 up by one, top first
                rem_nxt     = count_r - pos_m1;
                rd_addr_nxt = pal_pkg::ADDR_W'(count_r - pal_pkg::CNT_W'(1));
                state_nxt   = S_WALK;
              end
            end
            pal_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                status_nxt = pal_pkg::ST_EMPTY;
              end else if (in_pos == '0 || in_pos > count_r) begin
                status_nxt = pal_pkg::ST_BADPOS;
              end else begin
                // first read is the removed entry, the rest move down
                rem_nxt     = count_r - pos_m1;
                rd_addr_nxt = pos_m1[pal_pkg::ADDR_W-1:0];
                state_nxt   = S_WALK;
              end
            end
            pal_pkg::OP_LOCATE: begin
              rem_nxt     = count_r;
              rd_addr_nxt = '0;
              state_nxt   = S_WALK;
            end
            pal_pkg::OP_GET: begin
              if (in_pos == '0 || in_pos > count_r) begin
                status_nxt = pal_pkg::ST_BADPOS;
              end else begin
                rem_nxt     = pal_pkg::CNT_W'(1);
                rd_addr_nxt = pos_m1[pal_pkg::ADDR_W-1:0];
                state_nxt   = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        if (loc_hit) begin
          fp_nxt    = pal_pkg::CNT_W'(pend_addr_r) + pal_pkg::CNT_W'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else begin
          // data of the previous read: capture or write back shifted
          if (pend_r) begin
            if (pend_first_r &&
                (op_r == pal_pkg::OP_DELETE || op_r == pal_pkg::OP_GET)) begin
              rv_nxt = ram_rdata;
            end
            if (op_r == pal_pkg::OP_INSERT) begin
              ram_we    = 1'b1;
              ram_waddr = pend_addr_r + pal_pkg::ADDR_W'(1);
            end else if (op_r == pal_pkg::OP_DELETE && !pend_first_r) begin
              ram_we    = 1'b1;
              ram_waddr = pend_addr_r - pal_pkg::ADDR_W'(1);
            end
          end

          if (rem_r != '0) begin
            pend_nxt       = 1'b1;
            pend_first_nxt = first_r;
            pend_addr_nxt  = rd_addr_r;
            first_nxt      = 1'b0;
            rem_nxt        = rem_r - pal_pkg::CNT_W'(1);
            rd_addr_nxt    = walk_up ? rd_addr_r + pal_pkg::ADDR_W'(1)
                                     : rd_addr_r - pal_pkg::ADDR_W'(1);
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              // walk drained
              case (op_r)
                pal_pkg::OP_INSERT: state_nxt = S_INSWR;
                pal_pkg::OP_DELETE: begin
                  count_nxt = count_r - pal_pkg::CNT_W'(1);
                  state_nxt = S_FIN;
                end
                pal_pkg::OP_LOCATE: begin
                  status_nxt = pal_pkg::ST_NOTFOUND;
                  state_nxt  = S_FIN;
                end
                default: state_nxt = S_FIN;
              endcase
            end
          end
        end
      end

      S_INSWR: begin
        ram_we    = 1'b1;
        ram_waddr = ins_addr_r;
        ram_wdata = val_r;
        count_nxt = count_r + pal_pkg::CNT_W'(1);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // result goes to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pal_pkg::OUT_TW'({count_r, fp_r, rv_r, status_r});
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    ins_addr_r   <= ins_addr_nxt;
    rd_addr_r    <= rd_addr_nxt;
    pend_first_r <= pend_first_nxt;
    pend_addr_r  <= pend_addr_nxt;
    status_r     <= status_nxt;
    rv_r         <= rv_nxt;
    fp_r         <= fp_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

// checks the positional list unit item by item against a local model of the list
// directed table first, then random segments that fill, search, drain and mix
module testbench;
  import pal_pkg::*;

  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_ITEMS   = 1775;
  localparam int SEGMENT_ITEMS  = 100;
  localparam int FULL_RETRIES   = 6;

  // opcodes the block has no use for
  localparam op_t OP_SPARE_LO  = 3'd5;
  localparam op_t OP_SPARE_MID = 3'd6;
  localparam op_t OP_SPARE_HI  = 3'd7;

  localparam data_t MOST_NEG = 32'h8000_0000;
  localparam data_t MOST_POS = 32'h7fff_ffff;
  localparam data_t ALL_ONES = 32'hffff_ffff;

  // random segment flavors
  localparam int MODE_FILL   = 0;
  localparam int MODE_SEARCH = 1;
  localparam int MODE_DRAIN  = 2;
  localparam int MODE_MIXED  = 3;

  typedef struct packed {
    status_t status;
    data_t   read_value;
    cnt_t    found_pos;
    cnt_t    length;
  } list_result_t;

  typedef struct packed {
    op_t          op;
    cnt_t         pos;
    data_t        value;
    logic         has_literal;
    list_result_t result;
  } directed_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [IN_TW-1:0]     in_tdata   = '0;
  logic                 out_tready = 1'b0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [OUT_TW-1:0]    out_tdata;

  // local copy of the list contents and length
  data_t          list_store [CAPACITY];
  int             list_len = 0;
  list_result_t   expected_q [$];

  int mismatches    = 0;
  int cycles        = 0;
  int items_sent    = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 85;
  int hold_requests = 0;
  int hold_served   = 0;
  int holdoff_left  = 0;

  // directed items; literal results only where they are obvious
  directed_row_t directed_rows [25] = '{
    // empty list after reset
    '{OP_GET,       7'd1,   32'd0,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd0}},
    '{OP_DELETE,    7'd1,   32'd0,        1'b1, '{ST_EMPTY,    32'd0, 7'd0, 7'd0}},
    '{OP_LOCATE,    7'd0,   32'd0,        1'b1, '{ST_NOTFOUND, 32'd0, 7'd0, 7'd0}},
    '{OP_SPARE_LO,  7'd0,   32'd0,        1'b1, '{ST_OK,       32'd0, 7'd0, 7'd0}},
    '{OP_SPARE_HI,  7'd127, ALL_ONES,     1'b1, '{ST_OK,       32'd0, 7'd0, 7'd0}},
    // insert position checks on an empty list
    '{OP_INSERT,    7'd0,   32'd1,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd0}},
    '{OP_INSERT,    7'd2,   32'd1,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd0}},
    // value extremes, append at head and tail
    '{OP_INSERT,    7'd1,   MOST_NEG,     1'b1, '{ST_OK,       32'd0, 7'd0, 7'd1}},
    '{OP_INSERT,    7'd2,   MOST_POS,     1'b1, '{ST_OK,       32'd0, 7'd0, 7'd2}},
    '{OP_INSERT,    7'd1,   ALL_ONES,     1'b0, '0},
    '{OP_INSERT,    7'd2,   32'd0,        1'b0, '0},
    '{OP_INSERT,    7'd5,   MOST_POS,     1'b0, '0},
    '{OP_GET,       7'd5,   32'd0,        1'b0, '0},
    '{OP_GET,       7'd6,   32'd0,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd5}},
    // duplicate value: first position wins
    '{OP_LOCATE,    7'd0,   MOST_POS,     1'b0, '0},
    '{OP_LOCATE,    7'd0,   32'h12345678, 1'b1, '{ST_NOTFOUND, 32'd0, 7'd0, 7'd5}},
    '{OP_DELETE,    7'd0,   32'd0,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd5}},
    '{OP_DELETE,    7'd6,   32'd0,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd5}},
    '{OP_DELETE,    7'd1,   32'd0,        1'b0, '0},
    '{OP_GET,       7'd127, 32'd0,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd4}},
    '{OP_INSERT,    7'd127, 32'd9,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd4}},
    '{OP_SPARE_MID, 7'd3,   32'd3,        1'b1, '{ST_OK,       32'd0, 7'd0, 7'd4}},
    '{OP_CLEAR,     7'd0,   32'd0,        1'b1, '{ST_OK,       32'd0, 7'd0, 7'd0}},
    '{OP_GET,       7'd1,   32'd0,        1'b1, '{ST_BADPOS,   32'd0, 7'd0, 7'd0}},
    '{OP_LOCATE,    7'd0,   MOST_NEG,     1'b1, '{ST_NOTFOUND, 32'd0, 7'd0, 7'd0}}
  };

  positional_array_list_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // applies one list operation to the local copy and returns what the block should answer
  function automatic list_result_t apply_list_op(op_t op, cnt_t pos, data_t value);
    list_result_t r;
    int p;
    r = '0;
    r.status = ST_OK;
    p = int'(pos);
    case (op)
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_INSERT: begin
        // full check comes ahead of the position check
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (int j = list_len; j >= p; j--) list_store[j] = list_store[j-1];
          list_store[p-1] = value;
          list_len++;
        end
      end
      OP_DELETE: begin
        // empty check comes ahead of the position check
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = list_store[p-1];
          for (int j = p; j < list_len; j++) list_store[j-1] = list_store[j];
          list_len--;
        end
      end
      OP_LOCATE: begin
        // scan from the tail so the lowest matching position is kept
        r.status = ST_NOTFOUND;
        for (int j = list_len - 1; j >= 0; j--) begin
          if (list_store[j] == value) begin
            r.status    = ST_OK;
            r.found_pos = cnt_t'(j + 1);
          end
        end
      end
      OP_GET: begin
        if (p < 1 || p > list_len) r.status = ST_BADPOS;
        else r.read_value = list_store[p-1];
      end
      default: ;
    endcase
    r.length = cnt_t'(list_len);
    return r;
  endfunction

  // offers one item, waits for the handshake, then books its expected result
  task automatic send_item(op_t op, cnt_t pos, data_t value, logic has_literal,
                           list_result_t literal);
    logic [IN_TW-1:0] word;
    list_result_t     predicted;
    word = '0;
    word[OP_W-1:0]              = op;
    word[OP_W +: POS_W]         = pos;
    word[OP_W+POS_W +: DATA_W]  = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    predicted = apply_list_op(op, pos, value);
    expected_q.push_back(has_literal ? literal : predicted);
    items_sent++;
  endtask

  // drop valid and hold off until the block has answered everything
  task automatic wait_list_settled();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // mostly legal positions, with zero, just past the end and the far range mixed in
  function automatic cnt_t pick_position(op_t op);
    int top;
    int r;
    top = (op == OP_INSERT) ? list_len + 1 : list_len;
    if (top < 1) top = 1;
    r = $urandom_range(99);
    if (r < 80) return cnt_t'($urandom_range(top, 1));
    if (r < 88) return '0;
    if (r < 95) return cnt_t'(top + $urandom_range(2, 1));
    return cnt_t'($urandom_range((1 << POS_W) - 1));
  endfunction

  // small pool for duplicates, values already stored for locate hits, extremes, full range
  function automatic data_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return data_t'($urandom_range(7));
    if (r < 55 && list_len > 0) return list_store[$urandom_range(list_len - 1)];
    if (r < 62) begin
      case ($urandom_range(3))
        0: return MOST_NEG;
        1: return MOST_POS;
        2: return ALL_ONES;
        default: return '0;
      endcase
    end
    return data_t'($urandom);
  endfunction

  task automatic random_item(int mode);
    op_t op;
    int  r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 90)      op = OP_INSERT;
        else if (r < 94) op = OP_GET;
        else if (r < 97) op = OP_LOCATE;
        else             op = OP_DELETE;
      end
      MODE_DRAIN: begin
        if (r < 70)      op = OP_DELETE;
        else if (r < 80) op = OP_INSERT;
        else if (r < 90) op = OP_GET;
        else             op = OP_LOCATE;
      end
      MODE_SEARCH: begin
        if (r < 40)      op = OP_LOCATE;
        else if (r < 75) op = OP_GET;
        else if (r < 90) op = OP_INSERT;
        else             op = OP_DELETE;
      end
      default: begin
        if (r < 3)       op = OP_CLEAR;
        else if (r < 6)  op = op_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        else if (r < 40) op = OP_INSERT;
        else if (r < 65) op = OP_DELETE;
        else if (r < 82) op = OP_LOCATE;
        else             op = OP_GET;
      end
    endcase
    send_item(op, pick_position(op), pick_value(), 1'b0, '0);
  endtask

  // field by field check of one result against the oldest expectation
  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic check_result(logic [OUT_TW-1:0] word);
    list_result_t want;
    list_result_t got;
    got.status     = word[ST_W-1:0];
    got.read_value = word[ST_W +: DATA_W];
    got.found_pos  = word[ST_W+DATA_W +: POS_W];
    got.length     = word[ST_W+DATA_W+POS_W +: CNT_W];
    if (expected_q.size() == 0) begin
      mismatches++;
      $display("%0t: result with none pending, expected nothing got %h", $time, got);
    end else begin
      want = expected_q.pop_front();
      check_field("status", DATA_W'(want.status), DATA_W'(got.status));
      check_field("read_value", want.read_value, got.read_value);
      check_field("found_position", DATA_W'(want.found_pos), DATA_W'(got.found_pos));
      check_field("list_length", DATA_W'(want.length), DATA_W'(got.length));
    end
  endtask

  // result side: check accepted items, then pick next ready (long hold-off when asked)
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        out_tready   <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served  <= hold_served + 1;
        holdoff_left <= HOLDOFF_CYCLES;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int mode;
    int phase;
    int seg;
    phase = 0;
    seg   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, sender idles a little, receiver a lot
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].value,
                directed_rows[i].has_literal, directed_rows[i].result);
    end

    // random segments; idling pattern changes by thirds of the run
    while (items_sent < RANDOM_ITEMS + $size(directed_rows)) begin
      if (phase == 0 && items_sent >= 600) begin
        wait_list_settled();
        send_idle_pct = 85;
        recv_idle_pct = 20;
        phase = 1;
      end else if (phase == 1 && items_sent >= 1200) begin
        wait_list_settled();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
      end
      mode = seg % 4;
      // long receiver stall while items keep coming, once early and once with no idling
      if (mode == MODE_SEARCH && (seg == 1 || (phase == 2 && hold_requests == 1)))
        hold_requests <= hold_requests + 1;
      if (mode == MODE_FILL) begin
        while (list_len < CAPACITY) random_item(MODE_FILL);
        // a few inserts into the full list
        repeat (FULL_RETRIES) send_item(OP_INSERT, pick_position(OP_INSERT), pick_value(),
                                        1'b0, '0);
      end else begin
        repeat (SEGMENT_ITEMS) random_item(mode);
      end
      seg++;
    end

    wait_list_settled();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pal_pkg.sv
rtl/pal_ram.sv
rtl/positional_array_list_unit.sv
verif/testbench.sv
